FILE: rtl/xpvs_pkg.sv
// shared constants and types for the x86 prefix / vex scanner
// no dependencies; every other file except xpvs_if.sv imports this package
package xpvs_pkg;

   localparam int unsigned MAX_INSN_BYTES = 15;
   localparam logic [3:0]  MAX_BYTES_4    = 4'(MAX_INSN_BYTES);
   localparam int unsigned QUEUE_DEPTH    = 4;

   // legacy prefix bytes
   localparam logic [7:0] PFX_OPSIZE   = 8'h66;
   localparam logic [7:0] PFX_ADDRSIZE = 8'h67;
   localparam logic [7:0] PFX_LOCK     = 8'hF0;
   localparam logic [7:0] PFX_REPNE    = 8'hF2;
   localparam logic [7:0] PFX_REP      = 8'hF3;
   localparam logic [7:0] PFX_SEG_ES   = 8'h26;
   localparam logic [7:0] PFX_SEG_CS   = 8'h2E;
   localparam logic [7:0] PFX_SEG_SS   = 8'h36;
   localparam logic [7:0] PFX_SEG_DS   = 8'h3E;
   localparam logic [7:0] PFX_SEG_FS   = 8'h64;
   localparam logic [7:0] PFX_SEG_GS   = 8'h65;
   localparam logic [7:0] PFX_VEX2     = 8'hC5;
   localparam logic [7:0] PFX_VEX3     = 8'hC4;
   localparam logic [7:0] PFX_EVEX     = 8'h62;
   localparam logic [3:0] REX_HIGH_NIBBLE = 4'h4;

   // legacy flag bit positions
   localparam int unsigned FLAG_OPSIZE   = 0;
   localparam int unsigned FLAG_ADDRSIZE = 1;
   localparam int unsigned FLAG_LOCK     = 2;
   localparam int unsigned FLAG_REPNE    = 3;
   localparam int unsigned FLAG_REP      = 4;

   // segment codes
   localparam logic [2:0] SEG_ES = 3'd1;
   localparam logic [2:0] SEG_CS = 3'd2;
   localparam logic [2:0] SEG_SS = 3'd3;
   localparam logic [2:0] SEG_DS = 3'd4;
   localparam logic [2:0] SEG_FS = 3'd5;
   localparam logic [2:0] SEG_GS = 3'd6;

   // vex kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_VEX2 = 2'd1;
   localparam logic [1:0] KIND_VEX3 = 2'd2;
   localparam logic [1:0] KIND_EVEX = 2'd3;

   // pp encodings
   localparam logic [1:0] PP_66 = 2'd1;
   localparam logic [1:0] PP_F3 = 2'd2;
   localparam logic [1:0] PP_F2 = 2'd3;

   // raw record passed from the scanner to the formatter
   typedef struct packed {
      logic        status;
      logic [3:0]  prefix_len;
      logic        opcode_pending;
      logic [4:0]  legacy_flags;
      logic [2:0]  segment;
      logic        has_rex;
      logic [3:0]  rex_bits;
      logic [1:0]  vex_kind;
      logic [23:0] payload;
   } rec_type;

endpackage

FILE: rtl/xpvs_if.sv
// valid/ready channel interfaces for the scanner's byte input and record output
// widths follow the scanner's field list; no package needed
interface xpvs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       first_of_insn;
   logic       last_available;

   modport source (output valid, output code_byte, output first_of_insn,
                   output last_available, input ready);
   modport sink   (input valid, input code_byte, input first_of_insn,
                   input last_available, output ready);
endinterface

interface xpvs_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [3:0] prefix_len;
   logic       opcode_pending;
   logic [4:0] legacy_flags;
   logic [2:0] segment;
   logic       has_rex;
   logic [3:0] rex_bits;
   logic [1:0] vex_kind;
   logic [4:0] vex_map;
   logic [4:0] vex_extra_reg;
   logic [5:0] vex_ext;
   logic [6:0] evex_ctrl;

   modport source (output valid, output status, output prefix_len, output opcode_pending,
                   output legacy_flags, output segment, output has_rex, output rex_bits,
                   output vex_kind, output vex_map, output vex_extra_reg, output vex_ext,
                   output evex_ctrl, input ready);
   modport sink   (input valid, input status, input prefix_len, input opcode_pending,
                   input legacy_flags, input segment, input has_rex, input rex_bits,
                   input vex_kind, input vex_map, input vex_extra_reg, input vex_ext,
                   input evex_ctrl, output ready);
endinterface

FILE: rtl/x86_prefix_vex_scanner_core.sv
// x86 prefix / rex / vex / evex scanner, one instruction byte per transfer
// the record from the byte transfer that ends the scan goes into the record queue,
//   then into the output register, and rsp valid rises once it is there
// throughput: one byte per cycle; the four-entry record queue lets the scanner keep
//   taking bytes while records wait, and input stalls only while all four entries are taken
// reset (synchronous): scanner back in the legacy phase with a clean record,
//   queue and output register empty
module x86_prefix_vex_scanner_core
   import xpvs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   xpvs_req_if.sink   req_chan,
   xpvs_rsp_if.source rsp_chan
);

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_not_empty;
   rec_type push_rec;
   rec_type head_rec;

   xpvs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_rec  (push_rec)
   );

   xpvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (push_rec),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_rec  (head_rec)
   );

   xpvs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rec       (head_rec),
      .q_pop       (q_pop),
      .rsp         (rsp_chan)
   );

endmodule

FILE: rtl/xpvs_front.sv
// byte scanner: tracks the prefix phase and pushes a raw record when the scan ends
// depends on xpvs_pkg and xpvs_req_if
module xpvs_front
   import xpvs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   xpvs_req_if.sink         req,
   input  logic             q_full,
   output logic             q_push,
   output rec_type          q_rec
);

   typedef enum logic [4:0] {
      PH_LEGACY = 5'b00001,
      PH_NEED1  = 5'b00010,
      PH_NEED2  = 5'b00100,
      PH_NEED3  = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in, phase_eff;
   logic [3:0]  cnt_ff, cnt_in, cnt_eff, cnt_inc;
   logic [4:0]  flags_ff, flags_in, flags_eff;
   logic [2:0]  seg_ff, seg_in, seg_eff;
   logic [1:0]  kind_ff, kind_in, kind_eff;
   logic [23:0] pay_ff, pay_in, pay_eff;
   logic        accept;
   logic        prefix_taken;
   logic [1:0]  slot;

   function automatic rec_type trunc_rec(input logic [3:0] len);
      rec_type r;
      r            = '0;
      r.status     = 1'b1;
      r.prefix_len = len;
      return r;
   endfunction

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      // a first byte restarts from a clean record
      phase_eff = req.first_of_insn ? PH_LEGACY : phase_ff;
      cnt_eff   = req.first_of_insn ? 4'd0 : cnt_ff;
      flags_eff = req.first_of_insn ? 5'd0 : flags_ff;
      seg_eff   = req.first_of_insn ? 3'd0 : seg_ff;
      kind_eff  = req.first_of_insn ? KIND_NONE : kind_ff;
      pay_eff   = req.first_of_insn ? 24'd0 : pay_ff;
      cnt_inc   = cnt_eff + 4'd1;

      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      flags_in     = flags_ff;
      seg_in       = seg_ff;
      kind_in      = kind_ff;
      pay_in       = pay_ff;
      q_push       = 1'b0;
      q_rec        = '0;
      prefix_taken = 1'b0;

      // payload slot for the next vex byte
      case (kind_eff)
         KIND_VEX2: slot = 2'd0;
         KIND_VEX3: slot = (phase_eff == PH_NEED2) ? 2'd0 : 2'd1;
         default:   slot = (phase_eff == PH_NEED3) ? 2'd0 :
                           (phase_eff == PH_NEED2) ? 2'd1 : 2'd2;
      endcase

      if (accept) begin
         phase_in = phase_eff;
         cnt_in   = cnt_eff;
         flags_in = flags_eff;
         seg_in   = seg_eff;
         kind_in  = kind_eff;
         pay_in   = pay_eff;

         if (phase_eff != PH_DONE) begin
            if (cnt_eff >= MAX_BYTES_4) begin
               q_push   = 1'b1;
               q_rec    = trunc_rec(cnt_eff);
               phase_in = PH_DONE;
            end else if (phase_eff == PH_LEGACY) begin
               case (req.code_byte)
                  PFX_OPSIZE: begin
                     flags_in[FLAG_OPSIZE] = 1'b1;
                     prefix_taken = 1'b1;
                  end
                  PFX_ADDRSIZE: begin
                     flags_in[FLAG_ADDRSIZE] = 1'b1;
                     prefix_taken = 1'b1;
                  end
                  PFX_LOCK: begin
                     flags_in[FLAG_LOCK] = 1'b1;
                     prefix_taken = 1'b1;
                  end
                  PFX_REPNE: begin
                     flags_in[FLAG_REPNE] = 1'b1;
                     prefix_taken = 1'b1;
                  end
                  PFX_REP: begin
                     flags_in[FLAG_REP] = 1'b1;
                     prefix_taken = 1'b1;
                  end
                  PFX_SEG_ES: begin
                     seg_in = SEG_ES;
                     prefix_taken = 1'b1;
                  end
                  PFX_SEG_CS: begin
                     seg_in = SEG_CS;
                     prefix_taken = 1'b1;
                  end
                  PFX_SEG_SS: begin
                     seg_in = SEG_SS;
                     prefix_taken = 1'b1;
                  end
                  PFX_SEG_DS: begin
                     seg_in = SEG_DS;
                     prefix_taken = 1'b1;
                  end
                  PFX_SEG_FS: begin
                     seg_in = SEG_FS;
                     prefix_taken = 1'b1;
                  end
                  PFX_SEG_GS: begin
                     seg_in = SEG_GS;
                     prefix_taken = 1'b1;
                  end
                  PFX_VEX2: begin
                     kind_in      = KIND_VEX2;
                     pay_in       = 24'd0;
                     phase_in     = PH_NEED1;
                     prefix_taken = 1'b1;
                  end
                  PFX_VEX3: begin
                     kind_in      = KIND_VEX3;
                     pay_in       = 24'd0;
                     phase_in     = PH_NEED2;
                     prefix_taken = 1'b1;
                  end
                  PFX_EVEX: begin
                     kind_in      = KIND_EVEX;
                     pay_in       = 24'd0;
                     phase_in     = PH_NEED3;
                     prefix_taken = 1'b1;
                  end
                  default: begin
                     q_push             = 1'b1;
                     q_rec.prefix_len   = cnt_eff;
                     q_rec.legacy_flags = flags_eff;
                     q_rec.segment      = seg_eff;
                     phase_in           = PH_DONE;
                     if (req.code_byte[7:4] == REX_HIGH_NIBBLE) begin
                        cnt_in           = cnt_inc;
                        q_rec.prefix_len = cnt_inc;
                        q_rec.has_rex    = 1'b1;
                        q_rec.rex_bits   = req.code_byte[3:0];
                     end else begin
                        q_rec.opcode_pending = 1'b1;
                     end
                  end
               endcase
               if (prefix_taken) begin
                  cnt_in = cnt_inc;
                  if (req.last_available || cnt_inc >= MAX_BYTES_4) begin
                     q_push   = 1'b1;
                     q_rec    = trunc_rec(cnt_inc);
                     phase_in = PH_DONE;
                  end
               end
            end else begin
               // vex / evex payload byte
               case (slot)
                  2'd0:    pay_in[7:0]   = req.code_byte;
                  2'd1:    pay_in[15:8]  = req.code_byte;
                  default: pay_in[23:16] = req.code_byte;
               endcase
               cnt_in = cnt_inc;
               if (phase_eff == PH_NEED1) begin
                  q_push             = 1'b1;
                  q_rec.prefix_len   = cnt_inc;
                  q_rec.legacy_flags = flags_eff;
                  q_rec.segment      = seg_eff;
                  q_rec.vex_kind     = kind_eff;
                  q_rec.payload      = pay_in;
                  phase_in           = PH_DONE;
               end else begin
                  phase_in = (phase_eff == PH_NEED3) ? PH_NEED2 : PH_NEED1;
                  if (req.last_available || cnt_inc >= MAX_BYTES_4) begin
                     q_push   = 1'b1;
                     q_rec    = trunc_rec(cnt_inc);
                     phase_in = PH_DONE;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEGACY;
         cnt_ff   <= 4'd0;
         flags_ff <= 5'd0;
         seg_ff   <= 3'd0;
         kind_ff  <= KIND_NONE;
         pay_ff   <= 24'd0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         flags_ff <= flags_in;
         seg_ff   <= seg_in;
         kind_ff  <= kind_in;
         pay_ff   <= pay_in;
      end
   end

endmodule

FILE: rtl/xpvs_queue.sv
// short record queue between the scanner and the formatter
// depends on xpvs_pkg (rec_type, QUEUE_DEPTH)
module xpvs_queue
   import xpvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output rec_type head_rec
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

   rec_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == DEPTH_C);
   assign not_empty = (count_ff != '0);
   assign head_rec  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

FILE: rtl/xpvs_back.sv
// formatter: unpacks vex / evex payload, merges pp, holds the output register
// depends on xpvs_pkg and xpvs_rsp_if
module xpvs_back
   import xpvs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_not_empty,
   input  rec_type   q_rec,
   output logic      q_pop,
   xpvs_rsp_if.source rsp
);

   logic       valid_ff;
   logic       status_ff;
   logic [3:0] len_ff;
   logic       opc_ff;
   logic [4:0] flags_ff, flags_in;
   logic [2:0] seg_ff;
   logic       rex_ff;
   logic [3:0] rex_bits_ff;
   logic [1:0] kind_ff;
   logic [4:0] map_ff, map_in;
   logic [4:0] vvvv_ff, vvvv_in;
   logic [5:0] ext_ff, ext_in;
   logic [6:0] ctrl_ff, ctrl_in;
   logic [7:0] p1, p2, p3, last_byte;

   assign q_pop = q_not_empty && (!valid_ff || rsp.ready);

   assign p1 = q_rec.payload[7:0];
   assign p2 = q_rec.payload[15:8];
   assign p3 = q_rec.payload[23:16];

   always_comb begin
      flags_in  = q_rec.legacy_flags;
      map_in    = 5'd0;
      vvvv_in   = 5'd0;
      ext_in    = 6'd0;
      ctrl_in   = 7'd0;
      last_byte = (q_rec.vex_kind == KIND_VEX2) ? p1 : p2;
      case (q_rec.vex_kind)
         KIND_VEX2: begin
            map_in    = 5'd1;
            ext_in[0] = ~p1[7];
            ext_in[5] = p1[2];
         end
         KIND_VEX3: begin
            map_in    = p1[4:0];
            ext_in[0] = ~p1[7];
            ext_in[1] = ~p1[6];
            ext_in[2] = ~p1[5];
            ext_in[4] = p2[7];
            ext_in[5] = p2[2];
         end
         KIND_EVEX: begin
            map_in    = {2'd0, p1[2:0]};
            ext_in[0] = ~p1[7];
            ext_in[1] = ~p1[6];
            ext_in[2] = ~p1[5];
            ext_in[3] = ~p1[4];
            ext_in[4] = p2[7];
            ext_in[5] = p3[5];
            ctrl_in   = {~p3[3], p3[7], p3[6], p3[4], p3[2:0]};
            vvvv_in[4] = ~p3[3];
         end
         default: begin
         end
      endcase
      if (q_rec.vex_kind != KIND_NONE) begin
         vvvv_in[3:0] = ~last_byte[6:3];
         case (last_byte[1:0])
            PP_66:   flags_in[FLAG_OPSIZE] = 1'b1;
            PP_F3:   flags_in[FLAG_REP]    = 1'b1;
            PP_F2:   flags_in[FLAG_REPNE]  = 1'b1;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff   <= q_rec.status;
         len_ff      <= q_rec.prefix_len;
         opc_ff      <= q_rec.opcode_pending;
         flags_ff    <= flags_in;
         seg_ff      <= q_rec.segment;
         rex_ff      <= q_rec.has_rex;
         rex_bits_ff <= q_rec.rex_bits;
         kind_ff     <= q_rec.vex_kind;
         map_ff      <= map_in;
         vvvv_ff     <= vvvv_in;
         ext_ff      <= ext_in;
         ctrl_ff     <= ctrl_in;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.status         = status_ff;
   assign rsp.prefix_len     = len_ff;
   assign rsp.opcode_pending = opc_ff;
   assign rsp.legacy_flags   = flags_ff;
   assign rsp.segment        = seg_ff;
   assign rsp.has_rex        = rex_ff;
   assign rsp.rex_bits       = rex_bits_ff;
   assign rsp.vex_kind       = kind_ff;
   assign rsp.vex_map        = map_ff;
   assign rsp.vex_extra_reg  = vvvv_ff;
   assign rsp.vex_ext        = ext_ff;
   assign rsp.evex_ctrl      = ctrl_ff;

endmodule

FILE: tb/sv/xpvs_checker.sv
// scoreboard for the x86 prefix / vex scanner: predicts each record from the byte
// transfers it sees and checks the record transfers against them, field by field
// depends on xpvs_pkg and the channel interfaces in xpvs_if.sv
module xpvs_checker
   import xpvs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   xpvs_req_if  req_chan,
   xpvs_rsp_if  rsp_chan,
   output int   fail_count,
   output int   records_pending
);

   localparam logic [2:0] SCAN_LEGACY = 3'd0;
   localparam logic [2:0] SCAN_DONE   = 3'd4;

   typedef struct packed {
      logic       status;
      logic [3:0] prefix_len;
      logic       opcode_pending;
      logic [4:0] legacy_flags;
      logic [2:0] segment;
      logic       has_rex;
      logic [3:0] rex_bits;
      logic [1:0] vex_kind;
      logic [4:0] vex_map;
      logic [4:0] vex_extra_reg;
      logic [5:0] vex_ext;
      logic [6:0] evex_ctrl;
   } scan_record_type;

   // scanner state as the predictor sees it; scan_phase also counts payload bytes still due
   logic [2:0]      scan_phase;
   logic [4:0]      bytes_seen;
   logic [4:0]      flag_bits;
   logic [2:0]      seg_code;
   logic [1:0]      form_kind;
   logic [23:0]     payload;
   scan_record_type expected_records[$];
   int              mismatch_count = 0;

   assign fail_count = mismatch_count;

   task automatic clear_scan();
      scan_phase = SCAN_LEGACY;
      bytes_seen = '0;
      flag_bits  = '0;
      seg_code   = '0;
      form_kind  = KIND_NONE;
      payload    = '0;
   endtask

   task automatic truncate(output scan_record_type r);
      r            = '0;
      r.status     = 1'b1;
      r.prefix_len = bytes_seen[3:0];
      scan_phase   = SCAN_DONE;
   endtask

   task automatic finish_record(inout scan_record_type r);
      r.prefix_len   = bytes_seen[3:0];
      r.legacy_flags = flag_bits;
      r.segment      = seg_code;
      scan_phase     = SCAN_DONE;
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic first, input logic last,
                            output bit emitted, output scan_record_type r);
      int unsigned total;
      int unsigned idx;
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [7:0]  p3;
      logic [7:0]  tail;
      bit          counted;
      emitted = 1'b0;
      counted = 1'b0;
      r       = '0;
      if (first)
         clear_scan();
      if (scan_phase == SCAN_DONE)
         return;
      if (bytes_seen >= MAX_INSN_BYTES) begin
         truncate(r);
         emitted = 1'b1;
         return;
      end

      if (scan_phase != SCAN_LEGACY) begin
         total = (form_kind == KIND_VEX2) ? 1 : (form_kind == KIND_VEX3) ? 2 : 3;
         idx   = total - scan_phase;
         if (idx > 2)
            idx = 2;
         payload[8*idx +: 8] |= b;
         bytes_seen++;
         scan_phase--;
         emitted = 1'b1;
         if (scan_phase == SCAN_LEGACY) begin
            p1 = payload[7:0];
            p2 = payload[15:8];
            p3 = payload[23:16];
            if (form_kind == KIND_VEX2) begin
               tail         = p1;
               r.vex_map    = 5'd1;
               r.vex_ext[0] = ~p1[7];
               r.vex_ext[5] = p1[2];
            end else begin
               tail         = p2;
               r.vex_ext[0] = ~p1[7];
               r.vex_ext[1] = ~p1[6];
               r.vex_ext[2] = ~p1[5];
               r.vex_ext[4] = p2[7];
               if (form_kind == KIND_VEX3) begin
                  r.vex_map    = p1[4:0];
                  r.vex_ext[5] = p2[2];
               end else begin
                  r.vex_map    = {2'b00, p1[2:0]};
                  r.vex_ext[3] = ~p1[4];
                  r.vex_ext[5] = p3[5];
                  r.evex_ctrl  = {~p3[3], p3[7], p3[6], p3[4], p3[2:0]};
               end
            end
            r.vex_extra_reg = {1'b0, ~tail[6:3]};
            if (form_kind == KIND_EVEX && !p3[3])
               r.vex_extra_reg[4] = 1'b1;
            // pp stands in for an implied legacy prefix
            case (tail[1:0])
               PP_66: flag_bits[FLAG_OPSIZE] = 1'b1;
               PP_F3: flag_bits[FLAG_REP]    = 1'b1;
               PP_F2: flag_bits[FLAG_REPNE]  = 1'b1;
               default: ;
            endcase
            r.vex_kind = form_kind;
            finish_record(r);
         end else if (last || bytes_seen >= MAX_INSN_BYTES) begin
            truncate(r);
         end else begin
            emitted = 1'b0;
         end
         return;
      end

      case (b)
         PFX_OPSIZE:   flag_bits[FLAG_OPSIZE]   = 1'b1;
         PFX_ADDRSIZE: flag_bits[FLAG_ADDRSIZE] = 1'b1;
         PFX_LOCK:     flag_bits[FLAG_LOCK]     = 1'b1;
         PFX_REPNE:    flag_bits[FLAG_REPNE]    = 1'b1;
         PFX_REP:      flag_bits[FLAG_REP]      = 1'b1;
         PFX_SEG_ES:   seg_code = SEG_ES;
         PFX_SEG_CS:   seg_code = SEG_CS;
         PFX_SEG_SS:   seg_code = SEG_SS;
         PFX_SEG_DS:   seg_code = SEG_DS;
         PFX_SEG_FS:   seg_code = SEG_FS;
         PFX_SEG_GS:   seg_code = SEG_GS;
         PFX_VEX2, PFX_VEX3, PFX_EVEX: begin
            form_kind  = (b == PFX_VEX2) ? KIND_VEX2 : (b == PFX_VEX3) ? KIND_VEX3 : KIND_EVEX;
            payload    = '0;
            scan_phase = {1'b0, form_kind};
         end
         default: begin
            counted = 1'b1;
            emitted = 1'b1;
            if (b[7:4] == REX_HIGH_NIBBLE) begin
               bytes_seen++;
               finish_record(r);
               r.has_rex  = 1'b1;
               r.rex_bits = b[3:0];
            end else begin
               // opcode byte: left for the next stage, not counted
               finish_record(r);
               r.opcode_pending = 1'b1;
            end
         end
      endcase
      if (!counted) begin
         bytes_seen++;
         if (last || bytes_seen >= MAX_INSN_BYTES) begin
            truncate(r);
            emitted = 1'b1;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      scan_record_type want;
      scan_record_type predicted;
      bit              emitted;
      if (reset) begin
         clear_scan();
         expected_records.delete();
      end else begin
         // compare before predicting so a same-edge byte cannot match its own record
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_records.size() == 0) begin
               $error("record transfer with none expected: status %0d prefix_len %0d",
                      rsp_chan.status, rsp_chan.prefix_len);
               mismatch_count++;
            end else begin
               want = expected_records.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_chan.status));
               check_field("prefix_len", 8'(want.prefix_len), 8'(rsp_chan.prefix_len));
               check_field("opcode_pending", 8'(want.opcode_pending),
                           8'(rsp_chan.opcode_pending));
               check_field("legacy_flags", 8'(want.legacy_flags),
                           8'(rsp_chan.legacy_flags));
               check_field("segment", 8'(want.segment), 8'(rsp_chan.segment));
               check_field("has_rex", 8'(want.has_rex), 8'(rsp_chan.has_rex));
               check_field("rex_bits", 8'(want.rex_bits), 8'(rsp_chan.rex_bits));
               check_field("vex_kind", 8'(want.vex_kind), 8'(rsp_chan.vex_kind));
               check_field("vex_map", 8'(want.vex_map), 8'(rsp_chan.vex_map));
               check_field("vex_extra_reg", 8'(want.vex_extra_reg),
                           8'(rsp_chan.vex_extra_reg));
               check_field("vex_ext", 8'(want.vex_ext), 8'(rsp_chan.vex_ext));
               check_field("evex_ctrl", 8'(want.evex_ctrl), 8'(rsp_chan.evex_ctrl));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            scan_byte(req_chan.code_byte, req_chan.first_of_insn, req_chan.last_available,
                      emitted, predicted);
            if (emitted)
               expected_records.push_back(predicted);
         end
      end
      records_pending <= expected_records.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
// top of the x86 prefix / vex scanner bench: clock, reset, byte stimulus, record-side
// stalls, idle watchdog and verdict; checking lives in xpvs_checker
// depends on xpvs_pkg, xpvs_if.sv, xpvs_checker and x86_prefix_vex_scanner_core
module tb_top
   import xpvs_pkg::*;
();

   localparam int RANDOM_ITEMS = 600;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   logic clock;
   logic reset;
   int   fail_count;
   int   records_pending;
   int   idle_cycles;
   int   burst_left;
   int   items_sent;

   logic [7:0] insn_bytes[$];
   logic [7:0] legacy_pfx[11];

   xpvs_req_if req_chan();
   xpvs_rsp_if rsp_chan();

   x86_prefix_vex_scanner_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   xpvs_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .fail_count      (fail_count),
      .records_pending (records_pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // no transfer on either side for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // record-side stalls: stretches of always-ready, coin flips, a fixed period, mostly stalled
   initial begin
      int mode;
      int hold;
      int tick;
      rsp_chan.ready = 1'b0;
      tick = 0;
      forever begin
         mode = $urandom_range(0, 3);
         hold = $urandom_range(20, 150);
         repeat (hold) begin
            @(negedge clock);
            tick++;
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= (tick % 5) > 1;
               default: rsp_chan.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid          <= 1'b1;
      req_chan.code_byte      <= b;
      req_chan.first_of_insn  <= first;
      req_chan.last_available <= last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_insn(input logic lead_first, input int cut_at);
      for (int i = 0; i < insn_bytes.size(); i++)
         send_byte(insn_bytes[i], (i == 0) ? lead_first : 1'b0, (i == cut_at));
   endtask

   initial begin
      int choice;
      int core;
      int cut;
      int keep;
      req_chan.valid          = 1'b0;
      req_chan.code_byte      = '0;
      req_chan.first_of_insn  = 1'b0;
      req_chan.last_available = 1'b0;
      reset       = 1'b1;
      burst_left  = 0;
      items_sent  = 0;
      legacy_pfx  = '{PFX_OPSIZE, PFX_ADDRSIZE, PFX_LOCK, PFX_REPNE, PFX_REP, PFX_SEG_ES,
                      PFX_SEG_CS, PFX_SEG_SS, PFX_SEG_DS, PFX_SEG_FS, PFX_SEG_GS};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset the scan is live without a first-byte mark; last segment wins
      insn_bytes = '{PFX_SEG_ES, PFX_OPSIZE, PFX_ADDRSIZE, PFX_LOCK, PFX_REPNE, PFX_REP,
                     PFX_SEG_CS, PFX_SEG_SS, PFX_SEG_DS, PFX_SEG_FS, PFX_SEG_GS,
                     {REX_HIGH_NIBBLE, 4'hF}};
      send_insn(1'b0, -1);
      send_byte(8'hFF, 1'b0, 1'b0);  // scan over, byte ignored
      insn_bytes = '{PFX_VEX2, 8'h00};
      send_insn(1'b1, -1);
      insn_bytes = '{PFX_VEX3, 8'hFF, 8'hFF};
      send_insn(1'b1, -1);
      insn_bytes = '{PFX_EVEX, 8'h00, 8'h00, 8'h00};
      send_insn(1'b1, -1);
      insn_bytes = '{PFX_VEX3, 8'hE2};  // buffer ends inside the payload
      send_insn(1'b1, 1);
      insn_bytes = '{PFX_REP};
      send_insn(1'b1, 0);
      insn_bytes = '{8'h00};  // bare opcode on the last byte is still complete
      send_insn(1'b1, 0);

      while (items_sent < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 19);
         insn_bytes.delete();
         if (choice < 2) begin
            // noise: raw bytes, with or without a first-byte mark
            repeat ($urandom_range(1, 6))
               insn_bytes.push_back(8'($urandom));
            send_insn(1'($urandom_range(0, 1)),
                      ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 5));
         end else begin
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 3))
               insn_bytes.push_back(legacy_pfx[$urandom_range(0, 10)]);
            case ($urandom_range(0, 4))
               0: insn_bytes.push_back({REX_HIGH_NIBBLE, 4'($urandom)});
               1: begin
                  insn_bytes.push_back(PFX_VEX2);
                  insn_bytes.push_back(8'($urandom));
               end
               2: begin
                  insn_bytes.push_back(PFX_VEX3);
                  repeat (2) insn_bytes.push_back(8'($urandom));
               end
               3: begin
                  insn_bytes.push_back(PFX_EVEX);
                  repeat (3) insn_bytes.push_back(8'($urandom));
               end
               default: insn_bytes.push_back(8'($urandom));
            endcase
            core = insn_bytes.size();
            if (choice < 4) begin
               // broken: cut short, the next instruction restarts the scan
               keep = $urandom_range(1, core);
               while (insn_bytes.size() > keep)
                  void'(insn_bytes.pop_back());
               cut  = -1;
            end else begin
               // opcode and operand bytes after the prefixes are ignored
               repeat ($urandom_range(0, 3))
                  insn_bytes.push_back(8'($urandom));
               keep = $urandom_range(0, 9);
               if (keep < 7)
                  cut = insn_bytes.size() - 1;
               else if (keep < 9)
                  cut = $urandom_range(0, insn_bytes.size() - 1);
               else
                  cut = -1;
            end
            send_insn(1'b1, cut);
         end
      end

      req_chan.valid <= 1'b0;
      while (records_pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
